// ===== rtl/bsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants of the billboard sprite projector
// Column count, fixed-point constants, CORDIC angle table, controller
// command/status bundles and a saturation helper.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int COLUMNS = 512;
  localparam int COL_W   = $clog2(COLUMNS);

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [1:0] CFG_FOV    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_TILE   = 2'd2;

  localparam logic [14:0] FOV_RST    = 15'd10923;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [7:0]  TILE_RST   = 8'd64;

  localparam logic [23:0]        MIN_DIST  = 24'd26;
  localparam logic signed [32:0] INV_GAIN  = 33'sd652032874;
  localparam logic signed [25:0] HALF_TURN = 26'sd8388608;

  // iterative divider widths
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 24;
  localparam int DIV_CW = $clog2(DIV_NW);

  typedef struct packed {
    logic       ld;
    logic       wr;
    logic       atan;
    logic       rel;
    logic       cos_step;
    logic       cfin;
    logic       perp;
    logic       test;
    logic       sdiv;
    logic       fin;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic culled;
    logic vis;
    logic sqrt_done;
    logic cdiv_done;
    logic sdiv_done;
  } sts_t;

  // CORDIC angle table in 2^-24 turn
  function automatic logic signed [25:0] atan_lut(input logic [3:0] i);
    logic signed [25:0] r;
    unique case (i)
      4'd0:    r = 26'sd2097152;
      4'd1:    r = 26'sd1238021;
      4'd2:    r = 26'sd654136;
      4'd3:    r = 26'sd332050;
      4'd4:    r = 26'sd166669;
      4'd5:    r = 26'sd83416;
      4'd6:    r = 26'sd41718;
      4'd7:    r = 26'sd20860;
      4'd8:    r = 26'sd10430;
      4'd9:    r = 26'sd5215;
      4'd10:   r = 26'sd2608;
      4'd11:   r = 26'sd1304;
      4'd12:   r = 26'sd652;
      4'd13:   r = 26'sd326;
      4'd14:   r = 26'sd163;
      4'd15:   r = 26'sd81;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7FFF;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== rtl/billboard_sprite_projector_top.sv =====
// ----------------------------------------------------------------------------
// billboard_sprite_projector_top: billboard sprite projection against a
// per-column wall depth store
//
// Input stream: tuser selects the item kind (write depth or project).
// A write item stores one column's depth.
// A project item runs 16 atan2 CORDIC steps; unless the sprite is culled,
// it then runs 16 cosine steps, waits for the 32-step column divide (square
// root alongside), looks up the depth and, for a visible sprite, runs a
// 32-step size divide. tready rises as the result is loaded.
// One item is in work at a time.
// Output stream: one item per project item; tuser is the visible flag.
// The result sits in an output register, so the next item can be taken
// while the receiver stalls; a second result holds until the first leaves.
// Reset clears the sequencer and output valid and loads the default
// configuration; depth columns hold unknown data until written.
// ----------------------------------------------------------------------------
module billboard_sprite_projector_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,  // column, depth, sprite_x, sprite_y,
                                      // player_x, player_y, player_angle, scale
  input  logic         s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,  // screen_column, sprite_size, left_edge,
                                      // top_edge, sprite_distance
  output logic         m_axis_tuser,  // visible
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [14:0]  cfg_wdata_i
);
  import bsp_pkg::*;

  logic [14:0] fov_q;
  logic [11:0] height_q;
  logic [7:0]  tile_q;

  cmd_t cmd;
  sts_t sts;

  logic               visible;
  logic [8:0]         screen_column;
  logic [15:0]        sprite_size;
  logic signed [15:0] left_edge, top_edge;
  logic [23:0]        sprite_distance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fov_q    <= FOV_RST;
      height_q <= HEIGHT_RST;
      tile_q   <= TILE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FOV:    fov_q    <= cfg_wdata_i;
        CFG_HEIGHT: height_q <= cfg_wdata_i[11:0];
        CFG_TILE:   tile_q   <= cfg_wdata_i[7:0];
        default:    ;
      endcase
    end
  end

  bsp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_op_i    (s_axis_tuser),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid)
  );

  bsp_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .column_i          (s_axis_tdata[8:0]),
    .depth_i           (s_axis_tdata[32:9]),
    .sprite_x_i        (s_axis_tdata[56:33]),
    .sprite_y_i        (s_axis_tdata[80:57]),
    .player_x_i        (s_axis_tdata[104:81]),
    .player_y_i        (s_axis_tdata[128:105]),
    .player_angle_i    (s_axis_tdata[144:129]),
    .scale_i           (s_axis_tdata[156:145]),
    .fov_i             (fov_q),
    .height_i          (height_q),
    .tile_i            (tile_q),
    .visible_o         (visible),
    .screen_column_o   (screen_column),
    .sprite_size_o     (sprite_size),
    .left_edge_o       (left_edge),
    .top_edge_o        (top_edge),
    .sprite_distance_o (sprite_distance)
  );

  assign m_axis_tuser = visible;
  assign m_axis_tdata = {7'd0, sprite_distance, top_edge, left_edge, sprite_size,
                         screen_column};

endmodule

// ===== rtl/bsp_div.sv =====
// ----------------------------------------------------------------------------
// bsp_div: restoring unsigned divider
// One quotient bit per cycle; quotient valid when done_o is high again.
// ----------------------------------------------------------------------------
module bsp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bsp_pkg::DIV_NW-1:0] num_i,
  input  logic [bsp_pkg::DIV_DW-1:0] den_i,
  output logic                      done_o,
  output logic [bsp_pkg::DIV_NW-1:0] quo_o
);
  import bsp_pkg::*;

  logic              busy_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_DW-1:0] rem_q, den_q;
  logic [DIV_NW-1:0] quo_q;
  logic [DIV_DW+1:0] diff;
  logic              ge;

  assign diff = {1'b0, rem_q, quo_q[DIV_NW-1]} - {2'b0, den_q};
  assign ge   = ~diff[DIV_DW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(DIV_NW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DW-1:0] : {rem_q[DIV_DW-2:0], quo_q[DIV_NW-1]};
      quo_q <= {quo_q[DIV_NW-2:0], ge};
    end
  end

  assign done_o = ~busy_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/bsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsp_ctrl: sequencer of the sprite projector
// Steps one item through angle, cosine, distance, depth test and size,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module bsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_op_i,
  input  logic          m_ready_i,
  input  bsp_pkg::sts_t sts_i,
  output bsp_pkg::cmd_t cmd_o,
  output logic          s_ready_o,
  output logic          m_valid_o
);
  import bsp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_ATAN = 9'b000000010,
    S_REL  = 9'b000000100,
    S_COS  = 9'b000001000,
    S_WAIT = 9'b000010000,
    S_PERP = 9'b000100000,
    S_TEST = 9'b001000000,
    S_DIVS = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       ov_q, ov_d;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o     = '0;
    cmd_o.step = cnt_q;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (s_op_i == OP_PROJECT) begin
            cmd_o.ld = 1'b1;
            cnt_d    = '0;
            state_d  = S_ATAN;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      S_ATAN: begin
        cmd_o.atan = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == 4'd15) state_d = S_REL;
      end
      S_REL: begin
        cmd_o.rel = 1'b1;
        cnt_d     = '0;
        state_d   = sts_i.culled ? S_DONE : S_COS;
      end
      S_COS: begin
        cmd_o.cos_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == 4'd15) state_d = S_WAIT;
      end
      S_WAIT: begin
        cmd_o.cfin = 1'b1;
        if (sts_i.sqrt_done && sts_i.cdiv_done) state_d = S_PERP;
      end
      S_PERP: begin
        cmd_o.perp = 1'b1;
        state_d    = S_TEST;
      end
      S_TEST: begin
        cmd_o.test = 1'b1;
        if (sts_i.vis) begin
          cmd_o.sdiv = 1'b1;
          state_d    = S_DIVS;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIVS: begin
        if (sts_i.sdiv_done) state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!ov_q || m_ready_i) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ov_d = cmd_o.fin ? 1'b1 : (m_ready_i ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  assign m_valid_o = ov_q;

endmodule

// ===== rtl/bsp_dp.sv =====
// ----------------------------------------------------------------------------
// bsp_dp: datapath of the sprite projector
// Depth store, atan2 and cosine CORDIC, bit-serial square root, the
// column and size dividers and the result register.
// ----------------------------------------------------------------------------
module bsp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bsp_pkg::cmd_t       cmd_i,
  output bsp_pkg::sts_t       sts_o,
  input  logic [8:0]          column_i,
  input  logic [23:0]         depth_i,
  input  logic signed [23:0]  sprite_x_i,
  input  logic signed [23:0]  sprite_y_i,
  input  logic signed [23:0]  player_x_i,
  input  logic signed [23:0]  player_y_i,
  input  logic [15:0]         player_angle_i,
  input  logic [11:0]         scale_i,
  input  logic [14:0]         fov_i,
  input  logic [11:0]         height_i,
  input  logic [7:0]          tile_i,
  output logic                visible_o,
  output logic [8:0]          screen_column_o,
  output logic [15:0]         sprite_size_o,
  output logic signed [15:0]  left_edge_o,
  output logic signed [15:0]  top_edge_o,
  output logic [23:0]         sprite_distance_o
);
  import bsp_pkg::*;

  // depth store
  logic [23:0] mem [COLUMNS];
  logic [23:0] rd_q;

  // item registers
  logic signed [24:0] dx_q, dy_q;
  logic [15:0]        pa_q;
  logic [11:0]        scale_q;
  logic               zero_q;

  // atan2 CORDIC
  logic signed [35:0] xa_q, ya_q, xa_d, ya_d, xs, ys;
  logic signed [25:0] za_q, za_d, tab;

  // cosine CORDIC
  logic signed [32:0] cx_q, cy_q, cxs, cys;
  logic signed [25:0] cz_q;
  logic               cneg_q;
  logic signed [17:0] c_q;

  // square root
  logic [49:0] sqx_q, sqy_q, sn_q, sres_q, sbit_q, st;

  // angle and culling
  logic [15:0] srel_q;
  logic signed [25:0] zr;
  logic [15:0] ang, rel;
  logic [16:0] a17, a2;
  logic        big, culled;

  // column divide
  logic signed [17:0] cnum, cabs;
  logic [31:0]        cquo, squo;
  logic               cdone, sdone, cok;
  logic [COL_W-1:0]   sx_q;
  logic               colok_q;

  // distance and size
  logic signed [43:0] prod_q, pr;
  logic [23:0]        dist_c, dist_q;
  logic               vis_c, vis_q;
  logic [19:0]        p1_q;
  logic [31:0]        p2_q;

  // result
  logic [15:0]        size;
  logic [14:0]        half;
  logic signed [17:0] left_w, top_w;
  logic               ov_vis_q;
  logic [8:0]         ov_col_q;
  logic [15:0]        ov_size_q;
  logic signed [15:0] ov_left_q, ov_top_q;
  logic [23:0]        ov_dist_q;

  logic signed [24:0] dx_c, dy_c;
  logic signed [35:0] xi, yi;
  logic signed [32:0] cr, cc;

  assign dx_c = $signed({sprite_x_i[23], sprite_x_i}) - $signed({player_x_i[23], player_x_i});
  assign dy_c = $signed({sprite_y_i[23], sprite_y_i}) - $signed({player_y_i[23], player_y_i});
  assign xi   = $signed({{3{dx_c[24]}}, dx_c, 8'd0});
  assign yi   = $signed({{3{dy_c[24]}}, dy_c, 8'd0});

  assign tab = atan_lut(cmd_i.step);
  assign xs  = xa_q >>> cmd_i.step;
  assign ys  = ya_q >>> cmd_i.step;
  assign cxs = cx_q >>> cmd_i.step;
  assign cys = cy_q >>> cmd_i.step;

  always_comb begin
    if (!ya_q[35]) begin
      xa_d = xa_q + ys;
      ya_d = ya_q - xs;
      za_d = za_q + tab;
    end else begin
      xa_d = xa_q - ys;
      ya_d = ya_q + xs;
      za_d = za_q - tab;
    end
  end

  // relative angle, fold into the first quadrant for the cosine
  assign zr     = za_q + 26'sd128;
  assign ang    = zero_q ? 16'd0 : zr[23:8];
  assign rel    = ang - pa_q;
  assign a17    = rel[15] ? (17'd65536 - {1'b0, rel}) : {1'b0, rel};
  assign culled = (fov_i == 15'd0) || (a17 >= {2'b0, fov_i});
  assign big    = a17 > 17'd16384;
  assign a2     = big ? (17'd32768 - a17) : a17;

  // cosine rounded to Q16
  assign cr = cx_q + 33'sd8192;
  always_comb begin
    cc = cr >>> 14;
    if (cc > 33'sd65536) cc = 33'sd65536;
    else if (cc < -33'sd65536) cc = -33'sd65536;
  end

  // column: (2*rel + fov) * COLUMNS / (2*fov), truncated toward zero
  assign cnum = 18'($signed({srel_q, 1'b0})) + 18'($signed({1'b0, fov_i}));
  assign cabs = cnum[17] ? -cnum : cnum;
  assign cok  = (!cnum[17] || cquo == 32'd0) && (cquo < 32'(COLUMNS));

  bsp_div u_cdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cos_step && cmd_i.step == 4'd0),
    .num_i   (32'(cabs[16:0]) * 32'(COLUMNS)),
    .den_i   (24'({fov_i, 1'b0})),
    .done_o  (cdone),
    .quo_o   (cquo)
  );

  // perpendicular distance, clamped
  assign pr = prod_q >>> 16;
  always_comb begin
    if (pr < 44'sd26) dist_c = MIN_DIST;
    else if (pr > 44'sd16777215) dist_c = 24'hFFFFFF;
    else dist_c = pr[23:0];
  end
  assign vis_c = colok_q && (rd_q > dist_c);

  bsp_div u_sdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sdiv),
    .num_i   (p2_q),
    .den_i   (dist_c),
    .done_o  (sdone),
    .quo_o   (squo)
  );

  assign st = sres_q + sbit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sbit_q <= '0;
    end else if (cmd_i.atan && cmd_i.step == 4'd1) begin
      sbit_q <= 50'd1 << 48;
    end else if (sbit_q != '0) begin
      sbit_q <= sbit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && (32'(column_i) < 32'(COLUMNS))) mem[COL_W'(column_i)] <= depth_i;
    if (cmd_i.perp) rd_q <= mem[COL_W'(cquo)];

    if (cmd_i.ld) begin
      dx_q    <= dx_c;
      dy_q    <= dy_c;
      pa_q    <= player_angle_i;
      scale_q <= scale_i;
      zero_q  <= (dx_c == 25'sd0) && (dy_c == 25'sd0);
      if (dx_c[24]) begin
        xa_q <= -xi;
        ya_q <= -yi;
        za_q <= HALF_TURN;
      end else begin
        xa_q <= xi;
        ya_q <= yi;
        za_q <= '0;
      end
    end

    if (cmd_i.atan) begin
      xa_q <= xa_d;
      ya_q <= ya_d;
      za_q <= za_d;
      p1_q <= height_i * tile_i;
      if (cmd_i.step == 4'd0) begin
        sqx_q <= 50'(dx_q) * 50'(dx_q);
        sqy_q <= 50'(dy_q) * 50'(dy_q);
      end
    end

    // square root, one result bit per cycle
    if (cmd_i.atan && cmd_i.step == 4'd1) begin
      sn_q   <= sqx_q + sqy_q;
      sres_q <= '0;
    end else if (sbit_q != '0) begin
      if (sn_q >= st) begin
        sn_q   <= sn_q - st;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
    end

    if (cmd_i.rel) begin
      srel_q <= rel;
      vis_q  <= 1'b0;
      cneg_q <= big;
      cx_q   <= INV_GAIN;
      cy_q   <= '0;
      cz_q   <= $signed({1'b0, a2, 8'd0});
    end

    if (cmd_i.cos_step) begin
      p2_q <= p1_q * scale_q;
      if (!cz_q[25]) begin
        cx_q <= cx_q - cys;
        cy_q <= cy_q + cxs;
        cz_q <= cz_q - tab;
      end else begin
        cx_q <= cx_q + cys;
        cy_q <= cy_q - cxs;
        cz_q <= cz_q + tab;
      end
    end

    if (cmd_i.cfin) c_q <= cneg_q ? -cc[17:0] : cc[17:0];

    if (cmd_i.perp) begin
      prod_q  <= 44'($signed({1'b0, sres_q[24:0]})) * 44'(c_q);
      sx_q    <= COL_W'(cquo);
      colok_q <= cok;
    end

    if (cmd_i.test) begin
      dist_q <= dist_c;
      vis_q  <= vis_c;
    end

    if (cmd_i.fin) begin
      ov_vis_q  <= vis_q;
      ov_col_q  <= vis_q ? 9'(sx_q) : 9'd0;
      ov_size_q <= vis_q ? size : 16'd0;
      ov_left_q <= vis_q ? sat16(left_w) : 16'sd0;
      ov_top_q  <= vis_q ? sat16(top_w) : 16'sd0;
      ov_dist_q <= vis_q ? dist_q : 24'd0;
    end
  end

  assign size   = (squo > 32'd65535) ? 16'hFFFF : squo[15:0];
  assign half   = size[15:1];
  assign left_w = $signed(18'(sx_q)) - $signed({3'b0, half});
  assign top_w  = $signed({7'b0, height_i[11:1]}) - $signed({3'b0, half});

  assign sts_o.culled    = culled;
  assign sts_o.vis       = vis_c;
  assign sts_o.sqrt_done = (sbit_q == '0);
  assign sts_o.cdiv_done = cdone;
  assign sts_o.sdiv_done = sdone;

  assign visible_o         = ov_vis_q;
  assign screen_column_o   = ov_col_q;
  assign sprite_size_o     = ov_size_q;
  assign left_edge_o       = ov_left_q;
  assign top_edge_o        = ov_top_q;
  assign sprite_distance_o = ov_dist_q;

endmodule

// ===== rtl/bsp_checker.sv =====
// ----------------------------------------------------------------------------
// bsp_checker: port-level checks of the sprite projector
// Watches both streams and the sequencing seen at the ports.
// ----------------------------------------------------------------------------
module bsp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic         m_axis_tuser,
  input logic [87:0]  m_axis_tdata
);
  import bsp_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // hidden sprites carry all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 88'd0)
    else $error("hidden sprite with nonzero fields");

  // visible sprites respect the distance floor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[80:57] >= MIN_DIST)
    else $error("distance below floor");

  // a project item keeps the input closed on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_PROJECT) |=> !s_axis_tready)
    else $error("input reopened during projection");

endmodule

bind billboard_sprite_projector_top bsp_checker u_bsp_checker (.*);
